// ----- sv/serial_command_keyword_matcher_defines.svh -----
// Assertion macros used by the verification checker of the keyword matcher.
`ifndef SERIAL_COMMAND_KEYWORD_MATCHER_DEFINES_SVH
`define SERIAL_COMMAND_KEYWORD_MATCHER_DEFINES_SVH

// Same-cycle implication, checked while the reset is released.
`define SCKM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sckm assertion failed");

// Next-cycle implication, checked while the reset is released.
`define SCKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sckm assertion failed");

`endif

// ----- sv/sckm_pkg.sv -----
package sckm_pkg;

    // Command buffer geometry.
    localparam int BUFFER_LENGTH = 10;
    localparam int IDX_W         = 4;
    localparam int CHAR_W        = 7;
    localparam int KW_COUNT      = 16;
    localparam int KW_ID_W       = 4;
    localparam int KW_MAX_LEN    = 3;
    localparam int KW_LEN_W      = 2;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [IN_TDATA_W-1:0] CHAR_CR = 8'd13;

    typedef logic [CHAR_W-1:0]                  t_char;
    typedef logic [KW_MAX_LEN-1:0][CHAR_W-1:0]  t_head;
    typedef logic [IDX_W-1:0]                   t_idx;

    typedef struct packed {
        logic                 matched;
        logic [KW_ID_W-1:0]   command_id;
    } t_result;

    // Keyword lengths, by keyword number.
    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1
    };

    // Keyword text; position 0 is the first character, unused positions are zero.
    localparam t_char KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{7'h43, 7'h53, 7'h30}, '{7'h43, 7'h53, 7'h31}, '{7'h43, 7'h53, 7'h54},
        '{7'h4C, 7'h30, 7'h00}, '{7'h4C, 7'h31, 7'h00}, '{7'h4C, 7'h54, 7'h00},
        '{7'h54, 7'h00, 7'h00}, '{7'h53, 7'h00, 7'h00},
        '{7'h43, 7'h43, 7'h43}, '{7'h43, 7'h43, 7'h54}, '{7'h43, 7'h43, 7'h52},
        '{7'h43, 7'h43, 7'h30}, '{7'h43, 7'h43, 7'h31},
        '{7'h50, 7'h41, 7'h30}, '{7'h50, 7'h41, 7'h31},
        '{7'h4B, 7'h00, 7'h00}
    };

    // True for letters, digits, '+', '/' and '='.
    function automatic logic in_alphabet(input logic [IN_TDATA_W-1:0] b);
        logic ok;
        ok = ((b >= 8'h41) && (b <= 8'h5A)) ||
             ((b >= 8'h61) && (b <= 8'h7A)) ||
             ((b >= 8'h30) && (b <= 8'h39)) ||
             (b == 8'h2B) || (b == 8'h2F) || (b == 8'h3D);
        return ok;
    endfunction

    // Compares the buffered command against every keyword; the lowest number wins.
    function automatic t_result match_keyword(input t_head head, input t_idx len);
        t_result res;
        logic    eq;
        res = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            eq = (len == t_idx'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if ((i < int'(KW_LEN[k])) && (head[i] != KW_TEXT[k][i])) begin
                    eq = 1'b0;
                end
            end
            if (eq && !res.matched) begin
                res.matched    = 1'b1;
                res.command_id = KW_ID_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/serial_command_keyword_matcher.sv -----
// Serial command keyword matcher.
// The slave stream carries one received byte per transaction in tdata[7:0].
// Letters, digits, '+', '/' and '=' are collected as command text; a
// carriage return ends the command and any other byte is dropped silently.
// Each carriage return yields exactly one master transaction: tdata[0] is
// the match flag and tdata[4:1] the keyword number (zero without a match).
// A carriage return passes the input register and then the result register
// before its result is shown on the master side.
// Throughput: one byte per cycle. The only limit is the result register:
// while it holds a result that the receiver stalls, a carriage return waits
// in the input register and the slave side stops after that; text bytes
// keep flowing while the pending result is not yet taken.
// Reset (synchronous, active low) empties both registers and clears the
// write index and the first buffer entries; no clearing pass is needed.
// The write index wraps to zero after BUFFER_LENGTH text bytes.
module serial_command_keyword_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [sckm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] matched, [4:1] command_id, [7:5] zero
    output logic [sckm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import sckm_pkg::*;

    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_byte;
    t_idx                   r_idx;
    t_head                  r_head;
    logic                   r_out_valid;
    t_result                r_out;

    logic     out_free;
    logic     in_is_cr;
    logic     advance;
    t_idx     n_idx;
    t_head    n_head;
    t_result  n_out;

    // The stored byte moves on unless it needs the result slot and it is busy.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_is_cr        = (r_in_byte == CHAR_CR);
    assign advance         = r_in_valid && (!in_is_cr || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Buffer and index update, and the keyword compare.
    always_comb begin
        n_idx  = r_idx;
        n_head = r_head;
        n_out  = match_keyword(r_head, r_idx);
        if (in_is_cr) begin
            n_idx = '0;
        end else if (in_alphabet(r_in_byte)) begin
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (r_idx == t_idx'(i)) begin
                    n_head[i] = r_in_byte[CHAR_W-1:0];
                end
            end
            if (r_idx == t_idx'(BUFFER_LENGTH - 1)) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + t_idx'(1);
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // Command state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_head <= '0;
        end else if (advance) begin
            r_idx  <= n_idx;
            r_head <= n_head;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && in_is_cr) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && in_is_cr) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.command_id, r_out.matched};

endmodule

// ----- sv/sckm_checker.sv -----
`include "serial_command_keyword_matcher_defines.svh"

module sckm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic [sckm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [sckm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import sckm_pkg::*;

    logic s_cr_accept;

    assign s_cr_accept = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata == CHAR_CR);

    // A stalled result keeps its value.
    `SCKM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // Without a match the keyword number reads zero, and the pad bits stay zero.
    `SCKM_ASSERT_SAME(a_nomatch_id, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[7:1] == 7'd0)
    // The master side is empty right after reset.
    `SCKM_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_m_axis_tvalid)
    // In an empty pipeline a CR's result shows after the input and result registers.
    `SCKM_ASSERT_NEXT(a_cr_result, i_clk, i_rst_n, s_cr_accept && !o_m_axis_tvalid && $past(o_s_axis_tready) && !$past(i_s_axis_tvalid), ##1 o_m_axis_tvalid)

endmodule

bind serial_command_keyword_matcher sckm_checker u_sckm_checker (.*);
